/* rtl/pcxrle_pkg.sv */
// ----------------------------------------------------------------------------
// pcxrle_pkg
// Shared types and constants of the PCX run-length palette expander.
// ----------------------------------------------------------------------------
package pcxrle_pkg;

  // register and field widths
  localparam int CFG_W     = 11;
  localparam int TEXEL_W   = 21;
  localparam int COLOR_W   = 8;
  localparam int RGB_W     = 3 * COLOR_W;
  localparam int BYTE_W    = 8;
  localparam int RUN_W     = 6;
  localparam int PAL_DEPTH = 256;
  localparam int PAL_AW    = $clog2(PAL_DEPTH);

  // a byte above this value is a run marker
  localparam logic [BYTE_W-1:0] RUN_MARK_ABOVE = 8'hBF;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  // register indexes (paddr bit 2)
  localparam logic REG_WIDTH_IDX  = 1'b0;
  localparam logic REG_HEIGHT_IDX = 1'b1;

  // request codes on the input channel
  typedef enum logic [1:0] {
    REQ_PALETTE = 2'd0,
    REQ_DATA    = 2'd1,
    REQ_RESTART = 2'd2
  } req_e;

  // work handed from front to back
  typedef enum logic [1:0] {
    JOB_PALETTE = 2'd0,
    JOB_PIXELS  = 2'd1,
    JOB_RESTART = 2'd2
  } job_e;

  typedef struct packed {
    job_e               kind;
    logic [BYTE_W-1:0]  index;   // pixel byte or palette slot
    logic [RUN_W-1:0]   count;   // pixels still to emit
    logic [RGB_W-1:0]   rgb;     // palette entry color
  } job_t;

endpackage

/* rtl/pcxrle_ram.sv */
// ----------------------------------------------------------------------------
// pcxrle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pcxrle_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, data holds while not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/pcxrle_front.sv */
// ----------------------------------------------------------------------------
// pcxrle_front
// Takes input words, tracks run markers and makes a job of each word with work.
// ----------------------------------------------------------------------------
module pcxrle_front
  import pcxrle_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic [PAL_AW-1:0]  palette_slot_i,
  input  logic [COLOR_W-1:0] entry_red_i,
  input  logic [COLOR_W-1:0] entry_green_i,
  input  logic [COLOR_W-1:0] entry_blue_i,
  input  logic               full_i,
  output logic               push_o,
  output job_t               job_o
);

  logic             run_pending_q, run_pending_d;
  logic [RUN_W-1:0] run_len_q, run_len_d;
  logic             accept;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;

  // classify the accepted word
  always_comb begin
    run_pending_d = run_pending_q;
    run_len_d     = run_len_q;
    push_o        = 1'b0;
    job_o.kind    = JOB_PIXELS;
    job_o.index   = data_byte_i;
    job_o.count   = RUN_W'(1);
    job_o.rgb     = {entry_red_i, entry_green_i, entry_blue_i};
    if (accept) begin
      case (req_e'(req_type_i))
        REQ_PALETTE: begin
          push_o      = 1'b1;
          job_o.kind  = JOB_PALETTE;
          job_o.index = palette_slot_i;
        end
        REQ_RESTART: begin
          push_o        = 1'b1;
          job_o.kind    = JOB_RESTART;
          run_pending_d = 1'b0;
          run_len_d     = '0;
        end
        REQ_DATA: begin
          if (run_pending_q) begin
            // byte repeated by the pending marker, empty runs vanish
            run_pending_d = 1'b0;
            run_len_d     = '0;
            push_o        = (run_len_q != '0);
            job_o.count   = run_len_q;
          end else if (data_byte_i > RUN_MARK_ABOVE) begin
            run_pending_d = 1'b1;
            run_len_d     = data_byte_i[RUN_W-1:0];
          end else begin
            push_o = 1'b1;
          end
        end
        default: begin
          // reserved code is ignored
        end
      endcase
    end
  end

  // run marker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_pending_q <= 1'b0;
      run_len_q     <= '0;
    end else begin
      run_pending_q <= run_pending_d;
      run_len_q     <= run_len_d;
    end
  end

endmodule

/* rtl/pcxrle_fifo.sv */
// ----------------------------------------------------------------------------
// pcxrle_fifo
// Short job queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module pcxrle_fifo
  import pcxrle_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             slot_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   count_q;

  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign job_o   = slot_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + (PTR_W+1)'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - (PTR_W+1)'(1);
      end
    end
  end

endmodule

/* rtl/pcxrle_back.sv */
// ----------------------------------------------------------------------------
// pcxrle_back
// Executes jobs: palette writes, restarts and pixel runs with raster
// position tracking, palette lookup and the output register.
// ----------------------------------------------------------------------------
module pcxrle_back
  import pcxrle_pkg::*;
#(
  parameter int MAX_DIMENSION = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  job_t               job_i,
  input  logic               empty_i,
  output logic               pop_o,
  input  logic [CFG_W-1:0]   image_width_i,
  input  logic [CFG_W-1:0]   image_height_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TEXEL_W-1:0] texel_index_o,
  output logic [COLOR_W-1:0] red_o,
  output logic [COLOR_W-1:0] green_o,
  output logic [COLOR_W-1:0] blue_o,
  output logic               last_of_run_o,
  output logic               image_done_o
);

  localparam int ROW_W = $clog2(MAX_DIMENSION + 1);
  localparam int COL_W = $clog2(MAX_DIMENSION);
  localparam int EXT_W = ((CFG_W > ROW_W) ? CFG_W : ROW_W) + 1;
  localparam int SH_W  = $clog2(EXT_W + 1);

  logic               cur_valid_q;
  job_t               cur_q;
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic               out_valid_q;
  logic [TEXEL_W-1:0] texel_q;
  logic               last_q, done_q;

  logic [EXT_W-1:0]   w_eff, h_eff, w_ext, h_ext, max_ext;
  logic [EXT_W-1:0]   row_ext, col_ext;
  logic [SH_W-1:0]    stride_sh;
  logic [31:0]        texel_sum;
  logic               b_ready, past_end, row_last, col_last, img_done;
  logic               emit, is_last, cur_finish;
  logic [RGB_W-1:0]   rgb;

  // effective dimensions, zero acts as one, clamp to the maximum
  assign w_ext   = EXT_W'(image_width_i);
  assign h_ext   = EXT_W'(image_height_i);
  assign max_ext = EXT_W'(MAX_DIMENSION);
  assign w_eff   = (w_ext == '0) ? EXT_W'(1) : ((w_ext > max_ext) ? max_ext : w_ext);
  assign h_eff   = (h_ext == '0) ? EXT_W'(1) : ((h_ext > max_ext) ? max_ext : h_ext);

  // row stride is 2 to the bit length of the width
  always_comb begin
    stride_sh = '0;
    for (int i = 0; i < EXT_W; i++) begin
      if (w_eff[i]) begin
        stride_sh = SH_W'(i + 1);
      end
    end
  end

  // position tests for the current pixel
  assign row_ext   = EXT_W'(row_q);
  assign col_ext   = EXT_W'(col_q);
  assign past_end  = (row_ext >= h_eff);
  assign row_last  = ((row_ext + EXT_W'(1)) >= h_eff);
  assign col_last  = ((col_ext + EXT_W'(1)) >= w_eff);
  assign img_done  = row_last && col_last;
  assign texel_sum = (32'(row_q) << stride_sh) + 32'(col_q);

  assign b_ready = !out_valid_q || !out_stall_i;
  assign emit    = cur_valid_q && (cur_q.kind == JOB_PIXELS) && !past_end && b_ready;
  assign is_last = (cur_q.count == RUN_W'(1)) || img_done;

  // job completion and queue pop
  always_comb begin
    cur_finish = 1'b0;
    if (cur_valid_q) begin
      case (cur_q.kind)
        JOB_PALETTE: cur_finish = 1'b1;
        JOB_RESTART: cur_finish = 1'b1;
        JOB_PIXELS:  cur_finish = past_end || (emit && is_last);
        default:     cur_finish = 1'b1;
      endcase
    end
  end

  assign pop_o = !empty_i && (!cur_valid_q || cur_finish);

  // next raster position
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (cur_valid_q && (cur_q.kind == JOB_RESTART)) begin
      row_d = '0;
      col_d = '0;
    end else if (emit) begin
      if (col_last) begin
        col_d = '0;
        row_d = img_done ? ROW_W'(h_eff) : row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  // current job register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (pop_o) begin
      cur_valid_q <= 1'b1;
    end else if (cur_finish) begin
      cur_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= job_i;
    end else if (emit) begin
      cur_q.count <= cur_q.count - RUN_W'(1);
    end
  end

  // raster position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

  // palette store, looked up on each emitted pixel
  pcxrle_ram #(
    .WIDTH (RGB_W),
    .DEPTH (PAL_DEPTH)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (cur_valid_q && (cur_q.kind == JOB_PALETTE)),
    .waddr_i (cur_q.index),
    .wdata_i (cur_q.rgb),
    .re_i    (emit),
    .raddr_i (cur_q.index),
    .rdata_o (rgb)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      texel_q <= texel_sum[TEXEL_W-1:0];
      last_q  <= is_last;
      done_q  <= img_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign texel_index_o = texel_q;
  assign red_o         = rgb[RGB_W-1 -: COLOR_W];
  assign green_o       = rgb[COLOR_W +: COLOR_W];
  assign blue_o        = rgb[COLOR_W-1:0];
  assign last_of_run_o = last_q;
  assign image_done_o  = done_q;

endmodule

/* rtl/pcx_rle_palette_expander_top.sv */
// ----------------------------------------------------------------------------
// pcx_rle_palette_expander_top
// PCX 8-bit run-length decoder with palette expansion to RGB.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one word per cycle while the
// job queue is not full: a palette entry write, a compressed data byte or a
// restart. Output channel (out_valid_o / out_stall_i) delivers one RGB pixel
// per word with its texel address, last_of_run_o on the final pixel of a word
// and image_done_o on the last pixel of the image. Image width and height are
// written through the APB port (width at 0x0, height at 0x4); the user must
// write them only while the block is idle, the block does not enforce this. An
// accepted literal byte passes the job queue, the current job register and the
// output register before its pixel word appears. Literal bytes sustain one
// pixel per cycle while the output is not stalled; a run marker word pushes no
// job and its repeated byte then emits one pixel per cycle for the run length
// while not stalled, paced by the single palette read port in the back end.
// A 4-entry job queue between front and back keeps input flowing while a run
// is being expanded. Reset clears the run state, raster position and queue;
// the palette is not cleared and must be loaded before it is used. When
// out_stall_i is high the output word holds, pixel emission pauses and the
// front keeps accepting until the queue is full.
// ----------------------------------------------------------------------------
module pcx_rle_palette_expander_top
  import pcxrle_pkg::*;
#(
  parameter int MAX_DIMENSION = 1024
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input words
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic [PAL_AW-1:0]  palette_slot_i,
  input  logic [COLOR_W-1:0] entry_red_i,
  input  logic [COLOR_W-1:0] entry_green_i,
  input  logic [COLOR_W-1:0] entry_blue_i,
  // output words
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [TEXEL_W-1:0] texel_index_o,
  output logic [COLOR_W-1:0] red_o,
  output logic [COLOR_W-1:0] green_o,
  output logic [COLOR_W-1:0] blue_o,
  output logic               last_of_run_o,
  output logic               image_done_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [CFG_W-1:0] width_q, height_q;
  logic             cfg_wr;
  logic             push, pop, q_empty, q_full;
  job_t             push_job, head_job;

  // register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == REG_WIDTH_IDX) begin
        width_q <= pwdata[CFG_W-1:0];
      end else begin
        height_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == REG_HEIGHT_IDX) ? 32'(height_q) : 32'(width_q);

  // front end
  pcxrle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .req_type_i     (req_type_i),
    .data_byte_i    (data_byte_i),
    .palette_slot_i (palette_slot_i),
    .entry_red_i    (entry_red_i),
    .entry_green_i  (entry_green_i),
    .entry_blue_i   (entry_blue_i),
    .full_i         (q_full),
    .push_o         (push),
    .job_o          (push_job)
  );

  // job queue
  pcxrle_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // back end
  pcxrle_back #(
    .MAX_DIMENSION (MAX_DIMENSION)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (head_job),
    .empty_i        (q_empty),
    .pop_o          (pop),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .texel_index_o  (texel_index_o),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .last_of_run_o  (last_of_run_o),
    .image_done_o   (image_done_o)
  );

endmodule

/* rtl/pcxrle_checker.sv */
// ----------------------------------------------------------------------------
// pcxrle_checker
// Port-level checks of the PCX expander, bound to the top level.
// ----------------------------------------------------------------------------
module pcxrle_checker
  import pcxrle_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic [1:0]         req_type_i,
  input logic [BYTE_W-1:0]  data_byte_i,
  input logic [PAL_AW-1:0]  palette_slot_i,
  input logic [COLOR_W-1:0] entry_red_i,
  input logic [COLOR_W-1:0] entry_green_i,
  input logic [COLOR_W-1:0] entry_blue_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [TEXEL_W-1:0] texel_index_o,
  input logic [COLOR_W-1:0] red_o,
  input logic [COLOR_W-1:0] green_o,
  input logic [COLOR_W-1:0] blue_o,
  input logic               last_of_run_o,
  input logic               image_done_o,
  input logic               psel,
  input logic               pready
);

  // stalled input word holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(req_type_i)
      && $stable(data_byte_i) && $stable(palette_slot_i) && $stable(entry_red_i)
      && $stable(entry_green_i) && $stable(entry_blue_i))
    else $error("input word changed while stalled");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(texel_index_o)
      && $stable(red_o) && $stable(green_o) && $stable(blue_o)
      && $stable(last_of_run_o) && $stable(image_done_o))
    else $error("output word changed while stalled");

  // the image end always closes the pixels of its input word
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_done_o |-> last_of_run_o)
    else $error("image_done without last_of_run");

  // no output word straight out of reset
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output valid right after reset");

  // register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    psel |-> pready)
    else $error("pready low");

endmodule

bind pcx_rle_palette_expander_top pcxrle_checker u_checker (.*);

/* tb/tb_pcx_rle_palette_expander_top.sv */
// ----------------------------------------------------------------------------
// tb_pcx_rle_palette_expander_top
// Self-checking bench for the PCX run-length palette expander. Words are
// driven on the input channel and decoded in parallel by a predictor in the
// bench, which keeps its own palette, run state and raster position. Every
// pixel word leaving the block is compared field by field with the oldest
// predicted pixel. Directed tests cover literals, runs, zero-length runs,
// reserved words, restarts, dropped pixels past the image end, dimension
// clamping and size changes in the middle of an image; random traffic under
// three idle patterns follows.
// ----------------------------------------------------------------------------
module tb_pcx_rle_palette_expander_top;
  import pcxrle_pkg::*;

  localparam int MAX_DIMENSION = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_WORDS  = 30;

  // reserved request code, ignored by the block
  localparam logic [1:0] REQ_RESERVED = 2'd3;
  // lowest run marker byte
  localparam logic [BYTE_W-1:0] RUN_BASE = RUN_MARK_ABOVE + 8'd1;
  // register addresses
  localparam logic [2:0] WIDTH_ADDR  = {REG_WIDTH_IDX, 2'b00};
  localparam logic [2:0] HEIGHT_ADDR = {REG_HEIGHT_IDX, 2'b00};

  typedef struct packed {
    logic [TEXEL_W-1:0] texel;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last;
    logic               done;
  } pixel_t;

  // clock and reset
  logic clk = 1'b0;
  logic rst_ni = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // block ports
  logic               in_valid_i     = 1'b0;
  logic               in_stall_o;
  logic [1:0]         req_type_i     = '0;
  logic [BYTE_W-1:0]  data_byte_i    = '0;
  logic [PAL_AW-1:0]  palette_slot_i = '0;
  logic [COLOR_W-1:0] entry_red_i    = '0;
  logic [COLOR_W-1:0] entry_green_i  = '0;
  logic [COLOR_W-1:0] entry_blue_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i    = 1'b0;
  logic [TEXEL_W-1:0] texel_index_o;
  logic [COLOR_W-1:0] red_o;
  logic [COLOR_W-1:0] green_o;
  logic [COLOR_W-1:0] blue_o;
  logic               last_of_run_o;
  logic               image_done_o;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [2:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  pcx_rle_palette_expander_top #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) i_dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .data_byte_i   (data_byte_i),
    .palette_slot_i(palette_slot_i),
    .entry_red_i   (entry_red_i),
    .entry_green_i (entry_green_i),
    .entry_blue_i  (entry_blue_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .texel_index_o (texel_index_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .last_of_run_o (last_of_run_o),
    .image_done_o  (image_done_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // bench state
  int     fail_count    = 0;
  int     idle_cycles   = 0;
  int     send_idle_pct = 0;
  int     recv_idle_pct = 0;
  pixel_t pending_pixels[$];

  // predictor state
  logic [RGB_W-1:0] palette_rgb[PAL_DEPTH];
  bit               palette_loaded[PAL_DEPTH];
  bit               run_armed  = 1'b0;
  logic [RUN_W-1:0] run_count  = '0;
  int unsigned      raster_col = 0;
  int unsigned      raster_row = 0;
  logic [CFG_W-1:0] width_reg  = 11'd1;
  logic [CFG_W-1:0] height_reg = 11'd1;

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // place one pixel in raster order; returns 0 when the image is complete
  function automatic bit place_pixel(input logic [BYTE_W-1:0] code, output pixel_t px);
    int unsigned w;
    int unsigned h;
    int unsigned stride;
    int unsigned n;
    bit          done;
    w = (width_reg == 0) ? 1 : (width_reg > MAX_DIMENSION) ? MAX_DIMENSION : width_reg;
    h = (height_reg == 0) ? 1 : (height_reg > MAX_DIMENSION) ? MAX_DIMENSION : height_reg;
    stride = 1;
    for (n = w; n != 0; n = n >> 1) stride = stride << 1;
    if (raster_row >= h) return 1'b0;
    done = (raster_row + 1 >= h) && (raster_col + 1 >= w);
    px.texel = TEXEL_W'(raster_row * stride + raster_col);
    {px.red, px.green, px.blue} = palette_rgb[code];
    px.last = 1'b0;
    px.done = done;
    if (raster_col + 1 >= w) begin
      raster_col = 0;
      raster_row = done ? h : raster_row + 1;
    end else begin
      raster_col++;
    end
    return 1'b1;
  endfunction

  // decode one accepted word into the pixels it produces
  task automatic decode_word(input logic [1:0] kind, input logic [BYTE_W-1:0] code,
                             input logic [PAL_AW-1:0] slot, input logic [RGB_W-1:0] rgb);
    pixel_t px;
    pixel_t held;
    bit     have_held;
    int     i;
    have_held = 1'b0;
    case (kind)
      REQ_PALETTE: begin
        palette_rgb[slot]    = rgb;
        palette_loaded[slot] = 1'b1;
      end
      REQ_RESTART: begin
        raster_col = 0;
        raster_row = 0;
        run_armed  = 1'b0;
        run_count  = '0;
      end
      REQ_DATA: begin
        if (run_armed) begin
          run_armed = 1'b0;
          for (i = 0; i < int'(run_count); i++) begin
            if (place_pixel(code, px)) begin
              if (have_held) pending_pixels.push_back(held);
              held      = px;
              have_held = 1'b1;
            end
          end
          run_count = '0;
        end else if (code > RUN_MARK_ABOVE) begin
          run_armed = 1'b1;
          run_count = code[RUN_W-1:0];
        end else if (place_pixel(code, px)) begin
          held      = px;
          have_held = 1'b1;
        end
        // final pixel of this word carries the run end flag
        if (have_held) begin
          held.last = 1'b1;
          pending_pixels.push_back(held);
        end
      end
      default: ;
    endcase
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    out_stall_i <= ($urandom_range(99, 0) < recv_idle_pct);
  end

  // compare each accepted pixel word with the oldest prediction
  always @(posedge clk) begin : check_pixels
    pixel_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (pending_pixels.size() == 0) begin
        $error("unexpected pixel word: texel_index %0d", texel_index_o);
        fail_count++;
      end else begin
        want = pending_pixels.pop_front();
        check_field("texel_index", 32'(want.texel), 32'(texel_index_o));
        check_field("red", 32'(want.red), 32'(red_o));
        check_field("green", 32'(want.green), 32'(green_o));
        check_field("blue", 32'(want.blue), 32'(blue_o));
        check_field("last_of_run", 32'(want.last), 32'(last_of_run_o));
        check_field("image_done", 32'(want.done), 32'(image_done_o));
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if (!rst_ni || (in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
        (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // send one word, with a random gap before it
  task automatic send_word(input logic [1:0] kind, input logic [BYTE_W-1:0] code,
                           input logic [PAL_AW-1:0] slot, input logic [RGB_W-1:0] rgb);
    if ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk); while ($urandom_range(99, 0) < send_idle_pct);
    end
    in_valid_i     <= 1'b1;
    req_type_i     <= kind;
    data_byte_i    <= code;
    palette_slot_i <= slot;
    {entry_red_i, entry_green_i, entry_blue_i} <= rgb;
    do @(posedge clk); while (in_stall_o !== 1'b0);
    decode_word(kind, code, slot, rgb);
  endtask

  task automatic load_entry(input logic [PAL_AW-1:0] slot, input logic [RGB_W-1:0] rgb);
    send_word(REQ_PALETTE, BYTE_W'($urandom), slot, rgb);
  endtask

  task automatic push_byte(input logic [BYTE_W-1:0] code);
    send_word(REQ_DATA, code, PAL_AW'($urandom), RGB_W'($urandom));
  endtask

  task automatic restart_image();
    send_word(REQ_RESTART, BYTE_W'($urandom), PAL_AW'($urandom), RGB_W'($urandom));
  endtask

  task automatic send_reserved();
    send_word(REQ_RESERVED, BYTE_W'($urandom), PAL_AW'($urandom), RGB_W'($urandom));
  endtask

  task automatic send_run(input logic [RUN_W-1:0] len, input logic [BYTE_W-1:0] code);
    push_byte(RUN_BASE | BYTE_W'(len));
    push_byte(code);
  endtask

  // pixel values that only hit loaded palette entries
  function automatic logic [BYTE_W-1:0] pick_literal();
    logic [BYTE_W-1:0] v;
    do v = BYTE_W'($urandom_range(RUN_MARK_ABOVE, 0)); while (!palette_loaded[v]);
    return v;
  endfunction

  function automatic logic [BYTE_W-1:0] pick_any();
    logic [BYTE_W-1:0] v;
    do v = BYTE_W'($urandom_range(255, 0)); while (!palette_loaded[v]);
    return v;
  endfunction

  // hold input until every predicted pixel has arrived and the back end is quiet
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write followed by a read back
  task automatic write_register(input logic [2:0] addr, input logic [CFG_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {(32 - CFG_W)'($urandom_range(32'h1FFFFF, 0)), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (addr == WIDTH_ADDR) width_reg = value;
    else height_reg = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    check_field(addr == WIDTH_ADDR ? "image_width" : "image_height", 32'(value),
                32'(prdata[CFG_W-1:0]));
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_size(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    drain_results();
    write_register(WIDTH_ADDR, w);
    write_register(HEIGHT_ADDR, h);
  endtask

  // 1x1 image after reset: one pixel completes it, the next is dropped
  task automatic test_reset_defaults();
    load_entry(8'h00, 24'h000000);
    push_byte(8'h00);
    push_byte(8'h00);
    restart_image();
  endtask

  // literals, runs, zero-length run, reserved word, overflow and restart
  task automatic test_literals_and_runs();
    set_size(11'd4, 11'd2);
    load_entry(8'hFF, 24'hFFFFFF);
    load_entry(RUN_MARK_ABOVE, 24'hFF00FF);
    load_entry(RUN_BASE, 24'h00FF00);
    load_entry(8'h40, RGB_W'($urandom));
    push_byte(8'h00);
    push_byte(RUN_MARK_ABOVE);
    send_run(6'd3, 8'hFF);
    // zero-length run swallows the next byte
    send_run(6'd0, RUN_BASE);
    send_reserved();
    // longest run: only three pixels fit, the rest fall past the image end
    send_run(6'd63, 8'h40);
    push_byte(RUN_MARK_ABOVE);
    restart_image();
    // restart drops a pending run
    push_byte(RUN_BASE | 8'd2);
    restart_image();
    push_byte(8'h00);
    // palette write between marker and its byte
    push_byte(RUN_BASE | 8'd2);
    load_entry(8'h40, RGB_W'($urandom));
    push_byte(8'h40);
  endtask

  // clamped dimensions and a width change in the middle of an image
  task automatic test_config_extremes();
    set_size(11'd0, 11'd0);
    restart_image();
    push_byte(8'h00);
    push_byte(8'h00);
    set_size(11'd2047, 11'd2047);
    restart_image();
    send_run(6'd63, 8'hFF);
    set_size(11'd8, 11'd4);
    restart_image();
    send_run(6'd6, 8'h00);
    // column 6 now lies beyond the width: emits once, then wraps
    drain_results();
    write_register(WIDTH_ADDR, 11'd3);
    push_byte(RUN_MARK_ABOVE);
    send_run(6'd63, 8'hFF);
    set_size(11'd1024, 11'd1024);
    restart_image();
    push_byte(8'h00);
    set_size(11'd1, 11'd1);
    restart_image();
    push_byte(8'h00);
  endtask

  // walk far down a one-pixel-wide image, then widen it to reach high texels
  task automatic test_tall_raster();
    set_size(11'd1, 11'd1024);
    restart_image();
    repeat (9) send_run(6'd63, pick_any());
    drain_results();
    write_register(WIDTH_ADDR, 11'd1024);
    repeat (9) send_run(6'd63, pick_any());
    restart_image();
  endtask

  // random traffic, mostly well-formed, with one full drain halfway
  task automatic test_random_traffic(input int count);
    int               sent;
    int               sel;
    bit               paused;
    logic [RUN_W-1:0] len;
    sent   = 0;
    paused = 1'b0;
    set_size(CFG_W'($urandom_range(12, 0)), CFG_W'($urandom_range(6, 0)));
    restart_image();
    while (sent < count) begin
      if (!paused && sent >= count / 2) begin
        drain_results();
        paused = 1'b1;
      end
      sel = $urandom_range(99, 0);
      len = ($urandom_range(3, 0) == 0) ? RUN_W'($urandom_range(63, 0)) :
                                          RUN_W'($urandom_range(6, 0));
      if (sel < 12) begin
        load_entry(PAL_AW'($urandom), RGB_W'($urandom));
        sent += 1;
      end else if (sel < 16) begin
        restart_image();
        sent += 1;
      end else if (sel < 18) begin
        send_reserved();
        sent += 1;
      end else if (sel < 58) begin
        push_byte(pick_literal());
        sent += 1;
      end else if (sel < 90) begin
        send_run(len, pick_any());
        sent += 2;
      end else begin
        // broken run: another word lands between marker and its byte
        push_byte(RUN_BASE | BYTE_W'(len));
        case ($urandom_range(2, 0))
          0: restart_image();
          1: begin
            load_entry(PAL_AW'($urandom), RGB_W'($urandom));
            push_byte(pick_any());
          end
          default: begin
            send_reserved();
            push_byte(pick_any());
          end
        endcase
        sent += 3;
      end
    end
  endtask

  // test sequence
  initial begin
    repeat (2) @(posedge clk);
    rst_ni <= 1'b1;

    send_idle_pct = 21;
    recv_idle_pct = 72;
    test_reset_defaults();
    test_literals_and_runs();
    test_random_traffic(RANDOM_WORDS);

    drain_results();
    send_idle_pct = 72;
    recv_idle_pct = 21;
    test_config_extremes();
    test_random_traffic(RANDOM_WORDS);

    drain_results();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_tall_raster();
    test_random_traffic(RANDOM_WORDS);

    drain_results();
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
